// ===== sv/sorted_priority_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, codes and payload types shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] priority_val;
    } t_entry;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
        logic signed [31:0] priority_req;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic               empty_res;
        logic signed [31:0] head_value;
        logic signed [31:0] head_priority;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

    // Operation that every cell applies in the same cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one slot of the sorted store and shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  t_entry     i_new,
    input  t_entry     i_left,
    input  logic       i_left_ahead,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_ahead
);

    t_entry r_entry;
    t_entry n_entry;

    // An occupied entry stays ahead of a new one unless the new priority is
    // strictly greater, which keeps equal priorities in arrival order.
    assign o_ahead = i_occupied && !(i_new.priority_val > r_entry.priority_val);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.pop) begin
            n_entry = i_right;
        end else if (i_ctrl.push && !o_ahead) begin
            n_entry = i_left_ahead ? i_new : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Latency: the result of an item is strobed in the cycle after its transfer.
// Throughput: one push or pop per cycle; every cell of the chain compares
// and shifts in the same cycle, so busy never rises.
// Reset: synchronous, clears the entry count and the result strobe.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          r_status;
    t_status          n_status;
    logic             r_done;

    logic       accept;
    logic       full;
    logic       empty;
    t_cell_ctrl ctrl;
    t_entry     new_entry;
    t_entry     cell_entry [DEPTH];
    logic       cell_ahead [DEPTH];

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign new_entry = '{value: i_cmd.value, priority_val: i_cmd.priority_req};

    always_comb begin
        ctrl.push = accept && (i_cmd.kind == KIND_PUSH) && !full;
        ctrl.pop  = accept && (i_cmd.kind == KIND_POP) && !empty;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry left_entry;
            t_entry right_entry;
            logic   left_ahead;

            if (g == 0) begin : g_first
                assign left_entry = new_entry;
                assign left_ahead = 1'b1;
            end else begin : g_inner
                assign left_entry = cell_entry[g-1];
                assign left_ahead = cell_ahead[g-1];
            end

            // The tail slot is emptied by a pop, so what it loads is unused.
            if (g == DEPTH - 1) begin : g_last
                assign right_entry = new_entry;
            end else begin : g_body
                assign right_entry = cell_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_occupied   (r_count > CNT_W'(g)),
                .i_new        (new_entry),
                .i_left       (left_entry),
                .i_left_ahead (left_ahead),
                .i_right      (right_entry),
                .o_entry      (cell_entry[g]),
                .o_ahead      (cell_ahead[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
        if (accept && (i_cmd.kind == KIND_PUSH) && full) begin
            n_status = ST_FULL;
        end else if (accept && (i_cmd.kind == KIND_POP) && empty) begin
            n_status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // The result reads the store as the last transfer left it.
    always_comb begin
        o_result.status        = r_status;
        o_result.empty_res     = empty;
        o_result.head_value    = empty ? '0 : cell_entry[0].value;
        o_result.head_priority = empty ? '0 : cell_entry[0].priority_val;
        o_result.occupancy     = OCC_W'(r_count);
    end

    assign o_done = r_done;

    `SPQ_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, accept, o_done, "result strobe missing")
    `SPQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "count overflow")
    `SPQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, ctrl.push, r_count == $past(r_count) + 1'b1, "push count")
    `SPQ_ASSERT_SAME(a_empty_flag, i_clk, i_rst_n, o_done && (r_status == ST_EMPTY), empty, "bad empty")

endmodule

// ===== tb/sv/sorted_priority_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Sends push and pop commands through the start/busy handshake and checks
// every strobed report against a typed expectation or a behavioral sorted store.
// A short directed table covers the empty and full cases, priority extremes
// and arrival order within a priority. Random traffic follows, moving through
// fill, drain and churn phases with random gaps between transfers.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam int RANDOM_CMDS = 950;

    typedef struct {
        t_cmd    cmd;
        bit      fixed;
        t_result want;
    } t_stim_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    i_cmd = '0;
    logic    o_done;
    t_result o_result;

    // The typed expectation of a directed row travels with the command.
    bit      row_fixed = 1'b0;
    t_result row_want = '0;

    // Behavioral copy of the sorted store; slot 0 is the head.
    logic signed [31:0] held_value [DEPTH];
    logic signed [31:0] held_prio [DEPTH];
    int                 held = 0;

    t_result   want_reports[$];
    t_stim_row directed[$];

    int mismatches = 0;
    int n_push = 0;
    int n_pop = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_checked = 0;
    int peak = 0;
    int calm = 0;

    sorted_priority_queue_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("sorted_priority_queue_core regression: fail");
        $finish;
    end

    function automatic t_cmd mk_cmd(logic kind, logic [31:0] value, logic [31:0] prio);
        t_cmd c;
        c.kind = kind;
        c.value = value;
        c.priority_req = prio;
        return c;
    endfunction

    function automatic t_result mk_res(t_status s, logic [31:0] value, logic [31:0] prio,
                                       int occ);
        t_result r;
        r.status = s;
        r.empty_res = (occ == 0);
        r.head_value = value;
        r.head_priority = prio;
        r.occupancy = OCC_W'(occ);
        return r;
    endfunction

    function automatic void add_row(t_cmd c, bit fixed, t_result want);
        t_stim_row row;
        row.cmd = c;
        row.fixed = fixed;
        row.want = want;
        directed.push_back(row);
    endfunction

    // Applies one command to the store and returns the report it causes.
    function automatic t_result next_queue_report(t_cmd c);
        t_result r;
        int pos;
        r.status = ST_DONE;
        if (c.kind == KIND_PUSH) begin
            n_push++;
            if (held >= DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end else begin
                // The new entry goes behind every entry of greater or equal priority.
                pos = 0;
                while (pos < held && !($signed(c.priority_req) > held_prio[pos]))
                    pos++;
                for (int i = held; i > pos; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_value[pos] = c.value;
                held_prio[pos] = c.priority_req;
                held++;
            end
        end else begin
            n_pop++;
            if (held == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end else begin
                for (int i = 1; i < held; i++) begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1] = held_prio[i];
                end
                held--;
            end
        end
        if (held > peak)
            peak = held;
        r.empty_res = (held == 0);
        r.head_value = (held == 0) ? '0 : held_value[0];
        r.head_priority = (held == 0) ? '0 : held_prio[0];
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    function automatic void check_report(t_result want, t_result got);
        n_checked++;
        if (got.status !== want.status || got.empty_res !== want.empty_res ||
            got.head_value !== want.head_value || got.head_priority !== want.head_priority ||
            got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: ", $realtime,
                         "want st=%0d em=%0b hv=%h hp=%h occ=%0d, ",
                         want.status, want.empty_res, want.head_value,
                         want.head_priority, want.occupancy,
                         "got st=%0d em=%0b hv=%h hp=%h occ=%0d",
                         got.status, got.empty_res, got.head_value,
                         got.head_priority, got.occupancy);
        end
    endfunction

    // Outputs and handshake are sampled at the edge, before this edge's updates land.
    always @(posedge i_clk) begin : monitor
        t_result pred;
        if (i_rst_n) begin
            if (o_done) begin
                if (want_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected report with nothing outstanding", $realtime);
                end else begin
                    check_report(want_reports.pop_front(), o_result);
                end
            end
            if (start && !busy) begin
                pred = next_queue_report(i_cmd);
                want_reports.push_back(row_fixed ? row_want : pred);
            end
        end
    end

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap();
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_cmd random_cmd(int push_pct);
        logic [31:0] prio;
        int mode;
        mode = $urandom_range(0, 9);
        // A narrow priority band makes ties, and so arrival order, common.
        if (mode < 6)
            prio = 32'($urandom_range(0, 7)) - 32'd4;
        else if (mode < 8)
            prio = $urandom;
        else if (mode == 8)
            prio = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
        else
            prio = held > 0 ? held_prio[$urandom_range(0, held - 1)] : $urandom;
        return mk_cmd(($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP,
                      $urandom, prio);
    endfunction

    task automatic send_row(input t_cmd c, input bit fixed, input t_result want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        row_fixed <= fixed;
        row_want <= want;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic drain_reports();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (want_reports.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    initial begin : driver
        int push_pct;
        t_result none;
        none = '0;

        add_row(mk_cmd(KIND_POP, 32'h1234_5678, 32'h0BAD_F00D), 1'b1,
                mk_res(ST_EMPTY, 0, 0, 0));
        add_row(mk_cmd(KIND_PUSH, WORD_MAX, WORD_MIN), 1'b1,
                mk_res(ST_DONE, WORD_MAX, WORD_MIN, 1));
        add_row(mk_cmd(KIND_PUSH, WORD_MIN, WORD_MAX), 1'b1,
                mk_res(ST_DONE, WORD_MIN, WORD_MAX, 2));
        add_row(mk_cmd(KIND_PUSH, 32'sd5, WORD_MAX), 1'b1,
                mk_res(ST_DONE, WORD_MIN, WORD_MAX, 3));
        add_row(mk_cmd(KIND_POP, WORD_MAX, WORD_MAX), 1'b1,
                mk_res(ST_DONE, 32'sd5, WORD_MAX, 2));
        add_row(mk_cmd(KIND_POP, 32'h0, 32'h0), 1'b1,
                mk_res(ST_DONE, WORD_MAX, WORD_MIN, 1));
        add_row(mk_cmd(KIND_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                mk_res(ST_DONE, 0, 0, 0));
        add_row(mk_cmd(KIND_POP, 32'h0, 32'h0), 1'b1, mk_res(ST_EMPTY, 0, 0, 0));
        // Fill to capacity with rising priorities; the predictor checks these.
        for (int i = 0; i < DEPTH; i++)
            add_row(mk_cmd(KIND_PUSH, 32'hA000_0000 | 32'(i), 32'(i) - 32'd8), 1'b0, none);
        // A push into a full queue is dropped even when it outranks the head.
        add_row(mk_cmd(KIND_PUSH, 32'hFFFF_FFFF, WORD_MAX), 1'b1,
                mk_res(ST_FULL, 32'hA000_0000 | 32'(DEPTH - 1), 32'(DEPTH - 1) - 32'd8, DEPTH));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_row(directed[k].cmd, directed[k].fixed, directed[k].want);

        push_pct = 50;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 48 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            if (n == 300 || n == 650)
                drain_reports();
            send_row(random_cmd(push_pct), 1'b0, none);
        end

        drain_reports();
        repeat (4) @(posedge i_clk);
        if (want_reports.size() != 0) begin
            mismatches++;
            $display("%0d queue reports never arrived", want_reports.size());
        end

        $display("Checked %0d reports: %0d pushes (%0d dropped when full), ",
                 n_checked, n_push, n_full, "%0d pops (%0d on empty).", n_pop, n_empty);
        $display("Peak occupancy %0d of %0d entries; %0d mismatches.", peak, DEPTH, mismatches);
        if (mismatches == 0)
            $display("sorted_priority_queue_core regression: pass");
        else
            $display("sorted_priority_queue_core regression: fail");
        $finish;
    end

endmodule
